// File: rtl/core/pat_pkg.sv
package pat_pkg;

	localparam int SLOTS_DEF       = 256;
	localparam int BALLOT_BITS_DEF = 32;
	localparam int VALUE_BITS_DEF  = 64;

	// Number of codes the slot field can carry
	localparam int SLOT_CODES = 256;

	typedef enum logic [1:0] {
		MODE_PREPARE = 2'd0,
		MODE_ACCEPT  = 2'd1,
		MODE_GET     = 2'd2,
		MODE_BALANCE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  slot;
		logic        key_owned;
		logic [15:0] sender;
		logic [31:0] ballot;
		logic [31:0] instance_req;
		logic [31:0] accepted_ballot;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] reply_ballot;
		logic [31:0] reply_instance;
		logic [63:0] reply_value;
	} rsp_t;

endpackage

// File: rtl/core/pat_if.sv
interface pat_req_if import pat_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pat_rsp_if import pat_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/pat_mem.sv
module pat_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/pat_decide.sv
module pat_decide import pat_pkg::*; #(
	parameter int BALLOT_BITS = BALLOT_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int ENTRY_BITS  = 3 * BALLOT_BITS + 17 + VALUE_BITS
) (
	input  req_t                  item,
	input  logic                  hit,
	input  logic [ENTRY_BITS-1:0] old_entry,
	output logic                  wr,
	output logic [ENTRY_BITS-1:0] new_entry,
	output rsp_t                  reply
);

	typedef struct packed {
		logic [BALLOT_BITS-1:0] pb;
		logic [BALLOT_BITS-1:0] ab;
		logic [BALLOT_BITS-1:0] ai;
		logic [15:0]            ls;
		logic                   lsv;
		logic [VALUE_BITS-1:0]  av;
	} entry_t;

	entry_t                 e;
	entry_t                 ne;
	logic [BALLOT_BITS-1:0] n;
	logic [BALLOT_BITS-1:0] i;
	logic [BALLOT_BITS-1:0] na;
	logic [BALLOT_BITS-1:0] ai_kept;
	logic [VALUE_BITS-1:0]  val;
	logic                   same;

	assign e         = entry_t'(old_entry);
	assign n         = BALLOT_BITS'(item.ballot);
	assign i         = BALLOT_BITS'(item.instance_req);
	assign na        = BALLOT_BITS'(item.accepted_ballot);
	assign val       = VALUE_BITS'(item.payload);
	assign same      = e.lsv && (e.ls == item.sender);
	// a change of sender drops the accepted instance
	assign ai_kept   = same ? e.ai : '0;
	assign new_entry = ENTRY_BITS'(ne);

	always_comb begin
		ne                   = e;
		wr                   = 1'b0;
		reply.status         = ST_NONE;
		reply.reply_ballot   = '0;
		reply.reply_instance = '0;
		reply.reply_value    = '0;
		case (item.mode)
			MODE_GET: begin
				if (!hit || e.ab == '0) begin
					reply.status = ST_FAIL;
				end else begin
					reply.status         = ST_OK;
					reply.reply_ballot   = 32'(e.ab);
					reply.reply_instance = 32'(e.ai);
					reply.reply_value    = 64'(e.av);
				end
			end
			MODE_BALANCE: begin
				if (item.key_owned &&
				    (!hit || n > e.pb || (n == e.pb && i > e.ai))) begin
					wr     = 1'b1;
					ne.pb  = n;
					ne.ab  = na;
					ne.ai  = i;
					ne.ls  = '0;
					ne.lsv = 1'b0;
					ne.av  = val;
				end
			end
			MODE_PREPARE: begin
				if (hit || item.key_owned) begin
					wr = 1'b1;
					if (n > e.pb) begin
						ne.pb                = n;
						reply.status         = ST_OK;
						reply.reply_ballot   = 32'(n);
						reply.reply_instance = 32'(ai_kept);
					end else begin
						reply.status       = ST_FAIL;
						reply.reply_ballot = 32'(e.pb);
					end
				end
			end
			MODE_ACCEPT: begin
				if (hit || item.key_owned) begin
					wr                 = 1'b1;
					reply.status       = ST_FAIL;
					reply.reply_ballot = 32'(e.pb);
					reply.reply_instance = 32'(e.ai);
					if (n >= e.pb) begin
						if (i > ai_kept) begin
							ne.pb  = n;
							ne.ab  = n;
							ne.ai  = i;
							ne.av  = val;
							ne.ls  = item.sender;
							ne.lsv = 1'b1;
							reply.status         = ST_OK;
							reply.reply_ballot   = 32'(n);
							reply.reply_instance = 32'(i);
						end else begin
							ne.ai                = ai_kept;
							reply.reply_instance = 32'(ai_kept);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/paxos_acceptor_table.sv
// Paxos acceptor table: one acceptor record per key slot.
// req carries one message per request (mode, slot, ownership, sender,
// ballot, instance, accepted ballot, value word); rsp returns exactly one
// item per request, with status ok, fail or no reply.
// Throughput: one request per cycle sustained while the receiver keeps
// rsp.ready high. The table read is registered when the request is taken,
// and the result is registered into the response register after the
// decision logic, which is when the response becomes valid.
// The record memory has one read and one write port: it is read when a
// request is taken and written back, where the decision writes it, when that
// request leaves the decision stage; a request that follows one to the same
// slot takes the written record over a bypass register.
// Reset clears the per-slot valid bits at once, so the table reads as
// empty immediately after reset with no clearing pass; record contents
// are not reset.
// When the receiver holds rsp.ready low the response holds, the decision
// stage holds one more request, and req.ready drops until rsp moves.
// Slot codes at or beyond SLOTS wrap modulo SLOTS.
module paxos_acceptor_table import pat_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int BALLOT_BITS = BALLOT_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	pat_req_if.sink   req,
	pat_rsp_if.source rsp
);

	localparam int USED = (SLOTS < SLOT_CODES) ? SLOTS : SLOT_CODES;
	localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
	localparam int EW   = 3 * BALLOT_BITS + 17 + VALUE_BITS;

	typedef logic [AW-1:0] slot_map_t [SLOT_CODES];

	function automatic slot_map_t build_slot_map();
		slot_map_t m;
		for (int k = 0; k < SLOT_CODES; k++) begin
			m[k] = AW'(k % SLOTS);
		end
		return m;
	endfunction

	localparam slot_map_t SLOT_MAP = build_slot_map();

	logic            in_fire;
	logic            adv;
	logic [AW-1:0]   idx_in;
	logic            busy_s1;
	req_t            item_s1;
	logic [AW-1:0]   idx_s1;
	logic            fwd_s1;
	logic [EW-1:0]   fwd_entry_s1;
	logic [EW-1:0]   rd_entry;
	logic [EW-1:0]   old_entry;
	logic [EW-1:0]   new_entry;
	logic            hit;
	logic            dec_wr;
	logic            wr_en;
	rsp_t            reply;
	logic [USED-1:0] entry_valid_q;
	logic            rsp_valid_q;
	rsp_t            rsp_data_q;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !busy_s1 || adv;
	assign in_fire   = req.valid && req.ready;
	assign idx_in    = SLOT_MAP[req.data.slot];
	assign hit       = entry_valid_q[idx_s1];
	assign old_entry = !hit ? '0 : (fwd_s1 ? fwd_entry_s1 : rd_entry);
	assign wr_en     = busy_s1 && adv && dec_wr;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	pat_mem #(
		.WIDTH (EW),
		.DEPTH (USED),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (new_entry),
		.rd_en   (in_fire),
		.rd_addr (idx_in),
		.rd_data (rd_entry)
	);

	pat_decide #(
		.BALLOT_BITS (BALLOT_BITS),
		.VALUE_BITS  (VALUE_BITS),
		.ENTRY_BITS  (EW)
	) u_decide (
		.item      (item_s1),
		.hit       (hit),
		.old_entry (old_entry),
		.wr        (dec_wr),
		.new_entry (new_entry),
		.reply     (reply)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1       <= 1'b0;
			fwd_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			if (in_fire) begin
				busy_s1 <= 1'b1;
				// bypass the record being written this edge
				fwd_s1  <= wr_en && (idx_in == idx_s1);
			end else if (adv) begin
				busy_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= busy_s1;
			end
			if (wr_en) begin
				entry_valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1      <= req.data;
			idx_s1       <= idx_in;
			fwd_entry_s1 <= new_entry;
		end
		if (adv && busy_s1) begin
			rsp_data_q <= reply;
		end
	end

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> entry_valid_q[$past(idx_s1)])
		else $error("written slot not marked valid");

	a_get_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && item_s1.mode == MODE_GET) |-> !dec_wr)
		else $error("get request modified the table");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_data_q.status == ST_NONE) |->
		(rsp_data_q.reply_ballot == '0 && rsp_data_q.reply_instance == '0 &&
		 rsp_data_q.reply_value == '0))
		else $error("no-reply response carries data");

	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(fwd_s1) || (fwd_s1 && $past(in_fire))) |-> $past(wr_en))
		else $error("bypass taken without a write");

endmodule
